@@ hdl/ebl_pkg.sv @@
//------------------------------------------------------------------------------
// ebl_pkg
// shared types and constants of the expiring block list table
//------------------------------------------------------------------------------
`default_nettype none

package ebl_pkg;

   localparam int unsigned ENTRIES_DEFAULT = 256;
   localparam int unsigned KEY_W    = 64;
   localparam int unsigned NOW_W    = 32;
   localparam int unsigned TTL_W    = 31;
   localparam int unsigned EXP_W    = 33;
   localparam int unsigned COUNT_W  = 9;
   localparam int unsigned REQ_W    = 2;
   localparam logic [TTL_W-1:0] TTL_RESET = 31'd60;

   typedef enum logic [REQ_W-1:0] {
      REQ_RECORD = 2'd0,
      REQ_LOOKUP = 2'd1,
      REQ_SWEEP  = 2'd2,
      REQ_NONE   = 2'd3
   } req_type_type;

   // classified command handed from front to back
   typedef enum logic [1:0] {
      CMD_NOP    = 2'd0,
      CMD_RECORD = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_SWEEP  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic              do_sweep;
      logic [KEY_W-1:0]  key;
      logic [NOW_W-1:0]  now;
      logic [EXP_W-1:0]  expiry;
   } job_type;

endpackage

`default_nettype wire

@@ hdl/ebl_front.sv @@
//------------------------------------------------------------------------------
// ebl_front
// accepts requests, classifies them and queues jobs for the back end
//------------------------------------------------------------------------------
`default_nettype none

module ebl_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [ebl_pkg::REQ_W-1:0]     req_req_type,
   input  wire logic [ebl_pkg::KEY_W-1:0]     req_key,
   input  wire logic                          req_key_empty,
   input  wire logic [ebl_pkg::NOW_W-1:0]     req_now,
   input  wire logic [ebl_pkg::TTL_W-1:0]     ttl,
   output logic                               job_valid,
   input  wire logic                          job_take,
   output ebl_pkg::job_type                   job
);

   // two-entry job queue
   ebl_pkg::job_type                  q_ff [2];
   logic [1:0]                        cnt_ff, cnt_in;
   logic                              rd_ff, rd_in;
   logic                              wr_ff, wr_in;
   logic [ebl_pkg::NOW_W-1:0]         last_ff, last_in;
   ebl_pkg::job_type                  new_job;
   logic                              push, pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid & ~req_stall;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop       = job_valid & job_take;
   assign job       = q_ff[rd_ff];

   always_comb begin
      new_job.key      = req_key;
      new_job.now      = req_now;
      new_job.expiry   = {1'b0, req_now} + {2'b00, ttl};
      new_job.do_sweep = 1'b0;
      last_in          = last_ff;
      unique case (ebl_pkg::req_type_type'(req_req_type))
         ebl_pkg::REQ_RECORD: begin
            new_job.cmd = req_key_empty ? ebl_pkg::CMD_NOP : ebl_pkg::CMD_RECORD;
            if (!req_key_empty && req_now != last_ff) begin
               new_job.do_sweep = 1'b1;
               last_in          = req_now;
            end
         end
         ebl_pkg::REQ_LOOKUP:
            new_job.cmd = req_key_empty ? ebl_pkg::CMD_NOP : ebl_pkg::CMD_LOOKUP;
         ebl_pkg::REQ_SWEEP: begin
            new_job.cmd      = ebl_pkg::CMD_SWEEP;
            new_job.do_sweep = 1'b1;
         end
         default:
            new_job.cmd = ebl_pkg::CMD_NOP;
      endcase
      if (!push) last_in = last_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= new_job;
      if (reset) begin
         cnt_ff  <= '0;
         rd_ff   <= 1'b0;
         wr_ff   <= 1'b0;
         last_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         rd_ff   <= rd_in;
         wr_ff   <= wr_in;
         last_ff <= last_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/ebl_back.sv @@
//------------------------------------------------------------------------------
// ebl_back
// takes one job at a time, walks the slot table for it unless it is a no-op, and produces its result
//------------------------------------------------------------------------------
`default_nettype none

module ebl_back #(
   parameter int unsigned ENTRIES = ebl_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          job_valid,
   output logic                               job_take,
   input  wire ebl_pkg::job_type              job,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_blocked,
   output logic [ebl_pkg::COUNT_W-1:0]        rsp_entry_count
);

   localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam logic [IW:0] LAST = (IW+1)'(ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_WAIT, ST_EVICT, ST_WRITE, ST_OUT
   } state_type;

   // key and expiry memories, one read and one write port each
   logic [ebl_pkg::KEY_W-1:0] key_mem [ENTRIES];
   logic [ebl_pkg::EXP_W-1:0] exp_mem [ENTRIES];
   logic [ENTRIES-1:0]        valid_ff;

   state_type                  state_ff;
   ebl_pkg::job_type           job_ff;
   logic [IW:0]                idx_ff;      // read address issued
   logic                       rv_ff;       // read data valid
   logic [IW-1:0]              ridx_ff;     // index of read data
   logic [ebl_pkg::KEY_W-1:0]  rkey_ff;
   logic [ebl_pkg::EXP_W-1:0]  rexp_ff;
   logic [CW-1:0]              count_ff;
   logic                       hit_ff, free_ff, vic_ff;
   logic [IW-1:0]              hit_idx_ff, free_idx_ff, vic_idx_ff;
   logic [ebl_pkg::EXP_W-1:0]  vic_exp_ff;
   logic [ebl_pkg::EXP_W-1:0]  hit_exp_ff;  // expiry of the matched slot
   logic                       blocked_ff;
   logic                       rsp_valid_ff;

   logic                       rvalid, expired, alive;
   logic [IW-1:0]              ridx;
   logic                       wr_en;
   logic [IW-1:0]              wr_idx;

   assign ridx    = ridx_ff;
   assign rvalid  = rv_ff & valid_ff[ridx];
   assign expired = rvalid & job_ff.do_sweep & (rexp_ff <= {1'b0, job_ff.now});
   assign alive   = rvalid & ~expired;

   assign job_take        = (state_ff == ST_IDLE) & job_valid;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_blocked     = blocked_ff;
   assign rsp_entry_count = ebl_pkg::COUNT_W'(count_ff);

   always_comb begin
      wr_en  = (state_ff == ST_WRITE);
      wr_idx = hit_ff ? hit_idx_ff : free_idx_ff;
   end

   always_ff @(posedge clock) begin
      // registered memory reads
      rkey_ff <= key_mem[idx_ff[IW-1:0]];
      rexp_ff <= exp_mem[idx_ff[IW-1:0]];
      ridx_ff <= idx_ff[IW-1:0];
      if (wr_en) begin
         exp_mem[wr_idx] <= job_ff.expiry;
         if (!hit_ff) key_mem[wr_idx] <= job_ff.key;
      end

      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         rv_ff        <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         blocked_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  job_ff  <= job;
                  idx_ff  <= '0;
                  rv_ff   <= 1'b0;
                  hit_ff  <= 1'b0;
                  free_ff <= 1'b0;
                  vic_ff  <= 1'b0;
                  if (job.cmd == ebl_pkg::CMD_NOP) begin
                     blocked_ff   <= 1'b0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_OUT;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               // issue next address, evaluate the previous one
               rv_ff <= (idx_ff <= LAST);
               if (idx_ff <= LAST) idx_ff <= idx_ff + 1'b1;
               if (rv_ff) begin
                  if (expired) begin
                     valid_ff[ridx] <= 1'b0;
                     count_ff       <= count_ff - 1'b1;
                  end
                  if (alive && !hit_ff && rkey_ff == job_ff.key) begin
                     hit_ff     <= 1'b1;
                     hit_idx_ff <= ridx;
                     hit_exp_ff <= rexp_ff;
                  end
                  if (!alive && !free_ff) begin
                     free_ff     <= 1'b1;
                     free_idx_ff <= ridx;
                  end
                  if (alive && (!vic_ff || rexp_ff < vic_exp_ff)) begin
                     vic_ff      <= 1'b1;
                     vic_idx_ff  <= ridx;
                     vic_exp_ff  <= rexp_ff;
                  end
               end
               if (!(idx_ff <= LAST) && !rv_ff) state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               unique case (job_ff.cmd)
                  ebl_pkg::CMD_RECORD: begin
                     if (hit_ff || free_ff) state_ff <= ST_WRITE;
                     else                   state_ff <= ST_EVICT;
                  end
                  ebl_pkg::CMD_LOOKUP: begin
                     blocked_ff   <= hit_ff & (hit_exp_ff > {1'b0, job_ff.now});
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_OUT;
                  end
                  default: begin
                     blocked_ff   <= 1'b0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_OUT;
                  end
               endcase
            end
            ST_EVICT: begin
               // table full with no match: the victim slot becomes the free slot
               valid_ff[vic_idx_ff] <= 1'b0;
               count_ff             <= count_ff - 1'b1;
               free_ff              <= 1'b1;
               free_idx_ff          <= vic_idx_ff;
               state_ff             <= ST_WRITE;
            end
            ST_WRITE: begin
               if (!hit_ff) begin
                  valid_ff[free_idx_ff] <= 1'b1;
                  count_ff              <= count_ff + 1'b1;
               end
               blocked_ff   <= 1'b0;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

@@ hdl/expiring_block_list_table_unit.sv @@
//------------------------------------------------------------------------------
// expiring_block_list_table_unit
// keyed block list with per-entry expiry and earliest-expiry eviction
//------------------------------------------------------------------------------
// The back end walks the whole slot table once per request, but for an
// empty-key record or lookup or an unused request type, through a single
// read port of the key and expiry memories to sweep, match and pick a victim;
// a record that has to evict frees the victim slot before it writes. The back
// end takes no new job until the result beat of the last one has been taken,
// so a stalled beat holds it busy. A two-entry job queue lets the front
// accept requests while the back end is busy. One result beat per request.
`default_nettype none

module expiring_block_list_table_unit #(
   parameter int unsigned ENTRIES = ebl_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [ebl_pkg::REQ_W-1:0]     req_req_type,
   input  wire logic [ebl_pkg::KEY_W-1:0]     req_key,
   input  wire logic                          req_key_empty,
   input  wire logic [ebl_pkg::NOW_W-1:0]     req_now,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_blocked,
   output logic [ebl_pkg::COUNT_W-1:0]        rsp_entry_count,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ebl_pkg::TTL_W-1:0]     csr_ttl
);

   logic [ebl_pkg::TTL_W-1:0] ttl_ff;
   logic                      job_valid, job_take;
   ebl_pkg::job_type          job;

   assign csr_ready = 1'b1;

   // zero writes keep the old ttl
   always_ff @(posedge clock) begin
      if (reset) ttl_ff <= ebl_pkg::TTL_RESET;
      else if (csr_valid && csr_ttl != '0) ttl_ff <= csr_ttl;
   end

   ebl_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_req_type, .req_key,
      .req_key_empty, .req_now, .ttl(ttl_ff), .job_valid, .job_take, .job
   );

   ebl_back #(.ENTRIES(ENTRIES)) u_back (
      .clock, .reset, .job_valid, .job_take, .job, .rsp_valid, .rsp_stall,
      .rsp_blocked, .rsp_entry_count
   );

endmodule

`default_nettype wire

@@ sim/tb_expiring_block_list_table_unit.sv @@
//------------------------------------------------------------------------------
// tb_expiring_block_list_table_unit
// self-checking bench: directed and random requests run against a behavioral
// copy of the expiring table, with ttl changes while idle and random stalls
//------------------------------------------------------------------------------
`default_nettype none

module tb_expiring_block_list_table_unit;

   localparam int unsigned KEY_W   = ebl_pkg::KEY_W;
   localparam int unsigned NOW_W   = ebl_pkg::NOW_W;
   localparam int unsigned TTL_W   = ebl_pkg::TTL_W;
   localparam int unsigned EXP_W   = ebl_pkg::EXP_W;
   localparam int unsigned COUNT_W = ebl_pkg::COUNT_W;
   localparam int unsigned REQ_W   = ebl_pkg::REQ_W;

   localparam int unsigned SLOTS      = 256;
   localparam int unsigned IDLE_LIMIT = 5000;
   localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
   localparam logic [NOW_W-1:0] NOW_MAX  = {NOW_W{1'b1}};
   localparam logic [TTL_W-1:0] TTL_MAX  = {TTL_W{1'b1}};

   typedef struct {
      logic               blocked;
      logic [COUNT_W-1:0] count;
   } verdict_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [REQ_W-1:0]   req_req_type = '0;
   logic [KEY_W-1:0]   req_key = '0;
   logic               req_key_empty = 1'b0;
   logic [NOW_W-1:0]   req_now = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_blocked;
   logic [COUNT_W-1:0] rsp_entry_count;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [TTL_W-1:0]   csr_ttl = '0;

   // behavioral table
   logic               tab_valid [SLOTS];
   logic [KEY_W-1:0]   tab_key [SLOTS];
   logic [EXP_W-1:0]   tab_expiry [SLOTS];
   logic [NOW_W-1:0]   tab_last_sweep;
   int unsigned        tab_count;
   logic [TTL_W-1:0]   tab_ttl;

   verdict_type        pending_verdicts [$];
   logic [KEY_W-1:0]   key_pool [512];
   logic [NOW_W-1:0]   wall_time;
   int                 errors = 0;
   int                 stall_left = 0;
   int                 idle_cycles = 0;
   bit                 idle_on = 1'b1;

   expiring_block_list_table_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_req_type(req_req_type),
      .req_key(req_key), .req_key_empty(req_key_empty), .req_now(req_now),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_blocked(rsp_blocked),
      .rsp_entry_count(rsp_entry_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_ttl(csr_ttl)
   );

   always #6 clock = ~clock;

   task automatic sweep_table(input logic [EXP_W-1:0] t);
      for (int i = 0; i < SLOTS; i++) begin
         if (tab_valid[i] && tab_expiry[i] <= t) begin
            tab_valid[i] = 1'b0;
            tab_count--;
         end
      end
   endtask

   function automatic int find_slot(input logic [KEY_W-1:0] k);
      for (int i = 0; i < SLOTS; i++)
         if (tab_valid[i] && tab_key[i] == k) return i;
      return SLOTS;
   endfunction

   task automatic record_in_table(input logic [KEY_W-1:0] k, input logic [NOW_W-1:0] t);
      int pos;
      int victim;
      if (t != tab_last_sweep) begin
         sweep_table({1'b0, t});
         tab_last_sweep = t;
      end
      pos = find_slot(k);
      if (pos == SLOTS) begin
         if (tab_count >= SLOTS) begin
            victim = SLOTS;
            for (int i = 0; i < SLOTS; i++)
               if (tab_valid[i] && (victim == SLOTS || tab_expiry[i] < tab_expiry[victim]))
                  victim = i;
            if (victim < SLOTS) begin
               tab_valid[victim] = 1'b0;
               tab_count--;
            end
         end
         for (int i = 0; i < SLOTS; i++) begin
            if (!tab_valid[i]) begin
               pos = i;
               break;
            end
         end
         if (pos == SLOTS) return;
         tab_valid[pos] = 1'b1;
         tab_key[pos] = k;
         tab_count++;
      end
      tab_expiry[pos] = {1'b0, t} + {2'b00, tab_ttl};
   endtask

   // applies one accepted request to the table and queues the expected answer
   task automatic predict_table_step(input ebl_pkg::req_type_type rt,
                                     input logic [KEY_W-1:0] k,
                                     input logic e, input logic [NOW_W-1:0] t);
      verdict_type v;
      int pos;
      v.blocked = 1'b0;
      case (rt)
         ebl_pkg::REQ_RECORD: if (!e) record_in_table(k, t);
         ebl_pkg::REQ_LOOKUP: begin
            if (!e) begin
               pos = find_slot(k);
               if (pos < SLOTS && tab_expiry[pos] > {1'b0, t}) v.blocked = 1'b1;
            end
         end
         ebl_pkg::REQ_SWEEP: sweep_table({1'b0, t});
         default: ;
      endcase
      v.count = tab_count[COUNT_W-1:0];
      pending_verdicts.push_back(v);
   endtask

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_request(input ebl_pkg::req_type_type rt, input logic [KEY_W-1:0] k,
                               input logic e, input logic [NOW_W-1:0] t);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_req_type = rt;
      req_key = k;
      req_key_empty = e;
      req_now = t;
      do @(posedge clock); while (req_stall);
      predict_table_step(rt, k, e, t);
      @(negedge clock);
   endtask

   task automatic write_ttl(input logic [TTL_W-1:0] v);
      req_valid = 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      csr_valid = 1'b1;
      csr_ttl = v;
      do @(posedge clock); while (!csr_ready);
      if (v != '0) tab_ttl = v;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // response side stall bursts
   always @(negedge clock) begin
      if (idle_on && stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t result beat with nothing expected: blocked %0d count %0d",
                     $time, rsp_blocked, rsp_entry_count);
            errors++;
         end else begin
            if (rsp_blocked !== pending_verdicts[0].blocked) begin
               $display("%0t blocked mismatch: expected %0d actual %0d",
                        $time, pending_verdicts[0].blocked, rsp_blocked);
               errors++;
            end
            if (rsp_entry_count !== pending_verdicts[0].count) begin
               $display("%0t entry_count mismatch: expected %0d actual %0d",
                        $time, pending_verdicts[0].count, rsp_entry_count);
               errors++;
            end
            void'(pending_verdicts.pop_front());
         end
      end
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL expiring_block_list_table_unit");
         $finish;
      end
   end

   task automatic test_record_and_lookup;
      send_request(ebl_pkg::REQ_LOOKUP, '0, 1'b0, 32'd0);
      send_request(ebl_pkg::REQ_RECORD, '0, 1'b0, 32'd0);   // same second as reset, no sweep
      send_request(ebl_pkg::REQ_LOOKUP, '0, 1'b0, 32'd0);
      send_request(ebl_pkg::REQ_RECORD, KEY_ONES, 1'b0, 32'd0);
      send_request(ebl_pkg::REQ_LOOKUP, KEY_ONES, 1'b0, 32'd59);
      send_request(ebl_pkg::REQ_LOOKUP, KEY_ONES, 1'b0, 32'd60);   // expiry equal to now
      send_request(ebl_pkg::REQ_RECORD, KEY_ONES, 1'b0, 32'd30);   // refresh in place
      send_request(ebl_pkg::REQ_LOOKUP, KEY_ONES, 1'b0, 32'd60);
   endtask

   task automatic test_empty_and_unused;
      send_request(ebl_pkg::REQ_RECORD, 64'h5555_aaaa_5555_aaaa, 1'b1, 32'd61);
      send_request(ebl_pkg::REQ_LOOKUP, KEY_ONES, 1'b1, 32'd61);
      send_request(ebl_pkg::REQ_NONE, KEY_ONES, 1'b0, 32'd61);
      send_request(ebl_pkg::REQ_SWEEP, '0, 1'b1, 32'd90);   // sweep ignores key_empty
      send_request(ebl_pkg::REQ_LOOKUP, KEY_ONES, 1'b0, 32'd60);
   endtask

   task automatic test_ttl_extremes;
      write_ttl('0);                                        // ignored
      send_request(ebl_pkg::REQ_RECORD, 64'h1234, 1'b0, 32'd100);
      send_request(ebl_pkg::REQ_LOOKUP, 64'h1234, 1'b0, 32'd159);
      write_ttl(TTL_MAX);
      send_request(ebl_pkg::REQ_RECORD, 64'haaaa_5555_aaaa_5555, 1'b0, NOW_MAX);
      send_request(ebl_pkg::REQ_LOOKUP, 64'haaaa_5555_aaaa_5555, 1'b0, NOW_MAX);
      send_request(ebl_pkg::REQ_SWEEP, '0, 1'b0, NOW_MAX);
      write_ttl(31'd1);
      send_request(ebl_pkg::REQ_RECORD, 64'h77, 1'b0, 32'd5);
      send_request(ebl_pkg::REQ_LOOKUP, 64'h77, 1'b0, 32'd5);
      send_request(ebl_pkg::REQ_LOOKUP, 64'h77, 1'b0, 32'd6);
      send_request(ebl_pkg::REQ_RECORD, 64'h77, 1'b0, 32'd5);
      send_request(ebl_pkg::REQ_SWEEP, '0, 1'b0, NOW_MAX);
   endtask

   // mostly well-formed traffic on a small key set with a moving clock
   task automatic test_random_traffic(input logic [TTL_W-1:0] ttl_val, input int n,
                                      input int nkeys, input int max_step);
      int r;
      ebl_pkg::req_type_type rt;
      write_ttl(ttl_val);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            rt = ebl_pkg::req_type_type'($urandom_range(0, 3));
            send_request(rt, {$urandom, $urandom}, 1'($urandom_range(0, 1)), $urandom);
         end else begin
            wall_time = wall_time + NOW_W'($urandom_range(0, max_step));
            r = $urandom_range(0, 99);
            rt = (r < 60) ? ebl_pkg::REQ_RECORD :
                 (r < 95) ? ebl_pkg::REQ_LOOKUP : ebl_pkg::REQ_SWEEP;
            send_request(rt, key_pool[$urandom_range(0, nkeys - 1)], 1'b0, wall_time);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         tab_valid[i] = 1'b0;
         tab_key[i] = '0;
         tab_expiry[i] = '0;
      end
      tab_last_sweep = '0;
      tab_count = 0;
      tab_ttl = ebl_pkg::TTL_RESET;
      for (int i = 0; i < 512; i++) key_pool[i] = {$urandom, $urandom};
      wall_time = 32'd1000;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_record_and_lookup();
      test_empty_and_unused();
      test_ttl_extremes();
      test_random_traffic(31'd2000, 420, 400, 2);
      test_random_traffic(31'd5, 420, 64, 3);
      test_random_traffic(TTL_MAX, 420, 300, 1000);
      idle_on = 1'b0;
      test_random_traffic(31'd40, 420, 128, 2);
      req_valid = 1'b0;

      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (errors == 0) begin
         $display("PASS expiring_block_list_table_unit");
      end else begin
         $display("FAIL expiring_block_list_table_unit");
      end
      $finish;
   end

endmodule

`default_nettype wire
